@@ hw/rtl/fwp_pkg.sv @@
// package: types, constants and register indexes of the write-protect range decoder
`default_nettype none

package fwp_pkg;

    localparam int MAX_BP_BITS  = 4;
    localparam int BP_W         = MAX_BP_BITS;
    localparam int CSL_W        = 5;
    localparam int BPW_W        = 3;
    localparam int EXP_W        = 6;
    localparam int ADDR_W       = 32;
    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = 5;

    localparam int SECTOR_LOG2  = 12;
    localparam int BLOCK_LOG2   = 16;
    localparam int SEC_CAP_LOG2 = BLOCK_LOG2 - 1;

    localparam logic [CSL_W-1:0] RST_CHIP_SIZE_LOG2 = 5'd24;
    localparam logic [BPW_W-1:0] RST_BP_WIDTH       = 3'd3;
    localparam logic             RST_COEFF_OFFSET   = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CHIP_SIZE_LOG2     = 3'd0,
        CFG_BP_WIDTH           = 3'd1,
        CFG_FIXED_BLOCK        = 3'd2,
        CFG_CMP_INVERTS_BP     = 3'd3,
        CFG_COEFF_SHIFT_OFFSET = 3'd4,
        CFG_HAS_CMP            = 3'd5,
        CFG_HAS_SEC            = 3'd6,
        CFG_HAS_TB             = 3'd7
    } t_cfg_idx;

    typedef struct packed {
        logic [CSL_W-1:0] chip_size_log2;
        logic [BPW_W-1:0] bp_width;
        logic             fixed_block;
        logic             cmp_inverts_bp;
        logic             coeff_shift_offset;
        logic             has_cmp;
        logic             has_sec;
        logic             has_tb;
    } t_cfg;

    typedef struct packed {
        logic [BP_W-1:0] bp_field;
        logic            top_bottom;
        logic            sector_select;
        logic            complement;
    } t_in_item;

    typedef struct packed {
        logic [ADDR_W-1:0] range_start;
        logic [ADDR_W-1:0] range_length;
    } t_out_item;

endpackage

`default_nettype wire

@@ hw/rtl/fwp_in_if.sv @@
// interface: status bit transaction channel into the decoder
`default_nettype none

interface fwp_in_if import fwp_pkg::*;;
    logic     valid;
    logic     ready;
    t_in_item data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/fwp_out_if.sv @@
// interface: protected range transaction channel out of the decoder
`default_nettype none

interface fwp_out_if import fwp_pkg::*;;
    logic      valid;
    logic      ready;
    t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/fwp_cfg_regs.sv @@
// module: mode and geometry registers written through the plain write port
`default_nettype none

module fwp_cfg_regs import fwp_pkg::*; (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_wdata,
    output t_cfg                       o_cfg
);

    t_cfg r_cfg;
    t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_CHIP_SIZE_LOG2:     n_cfg.chip_size_log2     = i_cfg_wdata[CSL_W-1:0];
                CFG_BP_WIDTH:           n_cfg.bp_width           = i_cfg_wdata[BPW_W-1:0];
                CFG_FIXED_BLOCK:        n_cfg.fixed_block        = i_cfg_wdata[0];
                CFG_CMP_INVERTS_BP:     n_cfg.cmp_inverts_bp     = i_cfg_wdata[0];
                CFG_COEFF_SHIFT_OFFSET: n_cfg.coeff_shift_offset = i_cfg_wdata[0];
                CFG_HAS_CMP:            n_cfg.has_cmp            = i_cfg_wdata[0];
                CFG_HAS_SEC:            n_cfg.has_sec            = i_cfg_wdata[0];
                CFG_HAS_TB:             n_cfg.has_tb             = i_cfg_wdata[0];
                default:                n_cfg                    = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.chip_size_log2     <= RST_CHIP_SIZE_LOG2;
            r_cfg.bp_width           <= RST_BP_WIDTH;
            r_cfg.fixed_block        <= 1'b0;
            r_cfg.cmp_inverts_bp     <= 1'b0;
            r_cfg.coeff_shift_offset <= RST_COEFF_OFFSET;
            r_cfg.has_cmp            <= 1'b0;
            r_cfg.has_sec            <= 1'b0;
            r_cfg.has_tb             <= 1'b0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

@@ hw/rtl/fwp_decode.sv @@
// module: combinational decode of protect bits into a byte range: a power-of-two length, or its complement in the chip
`default_nettype none

module fwp_decode import fwp_pkg::*; (
    input  wire t_cfg      i_cfg,
    input  wire t_in_item  i_item,
    output t_out_item      o_item
);

    logic              cmp;
    logic              sec;
    logic              top;
    logic [BPW_W-1:0]  w;
    logic [BP_W-1:0]   bp_max;
    logic [BP_W-1:0]   bp;
    logic [BP_W-1:0]   e;
    logic [BP_W-1:0]   mexp;
    logic [CSL_W-1:0]  half_exp;
    logic [EXP_W-1:0]  blk_exp;
    logic [EXP_W-1:0]  need_exp;
    logic [EXP_W-1:0]  lexp;
    logic [CSL_W-1:0]  kexp;
    logic              len_zero;
    logic [ADDR_W-1:0] chip;
    logic [ADDR_W-1:0] len0;
    logic [ADDR_W-1:0] len;
    logic              top_eff;

    always_comb begin
        cmp = i_cfg.has_cmp & i_item.complement;
        sec = i_cfg.has_sec & i_item.sector_select;
        top = i_cfg.has_tb ? ~i_item.top_bottom : 1'b1;

        w      = (i_cfg.bp_width > BPW_W'(MAX_BP_BITS)) ? BPW_W'(MAX_BP_BITS) : i_cfg.bp_width;
        bp_max = BP_W'(((BP_W+1)'(1) << w) - (BP_W+1)'(1));
        bp     = i_item.bp_field & bp_max;
        if (cmp && i_cfg.cmp_inverts_bp) begin
            bp = bp ^ bp_max;
        end

        // exponents of the coefficient and of the largest coefficient
        e        = bp - BP_W'(i_cfg.coeff_shift_offset);
        mexp     = bp_max - BP_W'(i_cfg.coeff_shift_offset) - BP_W'(1);
        half_exp = i_cfg.chip_size_log2 - CSL_W'(1);

        // unless fixed_block is set, the block grows so the largest coefficient reaches half the chip
        blk_exp  = EXP_W'(BLOCK_LOG2);
        need_exp = EXP_W'(half_exp) - EXP_W'(mexp);
        if (!i_cfg.fixed_block && (i_cfg.chip_size_log2 != '0)
                && (EXP_W'(half_exp) >= EXP_W'(mexp)) && (need_exp > blk_exp)) begin
            blk_exp = need_exp;
        end

        if (sec) begin
            lexp = EXP_W'(SECTOR_LOG2) + EXP_W'(e);
            if (lexp > EXP_W'(SEC_CAP_LOG2)) begin
                lexp = EXP_W'(SEC_CAP_LOG2);
            end
        end else begin
            lexp = blk_exp + EXP_W'(e);
        end

        // saturate at chip size
        kexp = (lexp > EXP_W'(i_cfg.chip_size_log2)) ? i_cfg.chip_size_log2 : lexp[CSL_W-1:0];

        len_zero = 1'b0;
        if (bp == '0) begin
            len_zero = 1'b1;
        end else if (bp == bp_max) begin
            kexp = i_cfg.chip_size_log2;
        end

        chip    = ADDR_W'(1) << i_cfg.chip_size_log2;
        len0    = len_zero ? '0 : (ADDR_W'(1) << kexp);
        len     = cmp ? (chip - len0) : len0;
        top_eff = top ^ cmp;

        o_item.range_length = len;
        o_item.range_start  = (top_eff && (len != '0)) ? (chip - len) : '0;
    end

endmodule

`default_nettype wire

@@ hw/rtl/flash_write_protect_range_decode.sv @@
// top level: flash status register write-protect range decoder
//
//   channel   dir   handshake      payload
//   i_in      in    valid/ready    bp_field, top_bottom, sector_select, complement
//   o_out     out   valid/ready    range_start, range_length
//   i_cfg_*   in    write enable   register index, write data
//
// an accepted transaction passes the input register, then
// the decode logic into the result register
// one transaction per cycle sustained while o_out does not stall; the result register frees in the cycle it is taken
// synchronous active-low reset empties both stages and loads the register defaults
// a stall on o_out fills the input stage, then holds i_in.ready low
`default_nettype none

module flash_write_protect_range_decode import fwp_pkg::*; (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    fwp_in_if.sink                     i_in,
    fwp_out_if.source                  o_out,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_wdata
);

    t_cfg      cfg;
    t_out_item dec_item;

    logic      r_in_vld;
    t_in_item  r_in_item;
    logic      r_out_vld;
    t_out_item r_out_item;

    logic      out_load;
    logic      in_load;

    fwp_cfg_regs u_cfg_regs (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (cfg)
    );

    fwp_decode u_decode (
        .i_cfg  (cfg),
        .i_item (r_in_item),
        .o_item (dec_item)
    );

    assign out_load = !r_out_vld || o_out.ready;
    assign in_load  = !r_in_vld || out_load;

    assign i_in.ready  = in_load;
    assign o_out.valid = r_out_vld;
    assign o_out.data  = r_out_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (in_load) begin
                r_in_vld <= i_in.valid;
            end
            if (out_load) begin
                r_out_vld <= r_in_vld;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_load && i_in.valid) begin
            r_in_item <= i_in.data;
        end
        if (out_load && r_in_vld) begin
            r_out_item <= dec_item;
        end
    end

    // range stays inside the chip
    a_len_in_chip: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld |-> ({1'b0, r_out_item.range_length}
            <= ((ADDR_W+1)'(1) << cfg.chip_size_log2)))
        else $error("range length beyond chip size");

    a_end_in_chip: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld |-> (({1'b0, r_out_item.range_start} + {1'b0, r_out_item.range_length})
            <= ((ADDR_W+1)'(1) << cfg.chip_size_log2)))
        else $error("range end beyond chip size");

    a_empty_at_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && (r_out_item.range_length == '0)) |-> (r_out_item.range_start == '0))
        else $error("empty range with nonzero start");

    a_reset_empty: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> (!r_in_vld && !r_out_vld))
        else $error("stage valid after reset");

    a_stage_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_vld && out_load) |=> r_out_vld)
        else $error("decoded transaction lost between stages");

endmodule

`default_nettype wire

@@ test/tb_top.sv @@
// testbench: write-protect range decoder checked against a predictor, random stalls on both channels
`timescale 1ns / 1ps

module tb_top;
    import fwp_pkg::*;

    localparam int WATCHDOG_LIMIT = 1000;
    localparam int SEGMENTS       = 16;
    localparam int SEG_ITEMS      = 25;

    class protect_range_checker;
        t_out_item pending_ranges[$];
        int        errors;

        function new();
            errors = 0;
        endfunction

        function t_out_item decode_range(t_cfg c, t_in_item it);
            logic [63:0] chip, bp_max, bp, len, coeff, coeff_top, blk, need, start;
            int unsigned w, off;
            bit          cmp, sec, top;
            t_out_item   res;
            chip = 64'd1 << c.chip_size_log2;
            w = 32'(c.bp_width);
            if (w > MAX_BP_BITS) begin
                w = MAX_BP_BITS;
            end
            bp_max = (64'd1 << w) - 64'd1;
            bp = 64'(it.bp_field) & bp_max;
            cmp = c.has_cmp && it.complement;
            sec = c.has_sec && it.sector_select;
            top = c.has_tb ? !it.top_bottom : 1'b1;
            if (cmp && c.cmp_inverts_bp) begin
                bp = bp ^ bp_max;
            end
            if (bp == 64'd0) begin
                len = 64'd0;
            end else if (bp == bp_max) begin
                len = chip;
            end else begin
                off = 32'(c.coeff_shift_offset);
                coeff = 64'd1 << (bp - off);
                coeff_top = 64'd1 << (bp_max - off - 1);
                if (sec) begin
                    len = (64'd1 << SECTOR_LOG2) * coeff;
                    if (len > (64'd1 << SEC_CAP_LOG2)) begin
                        len = 64'd1 << SEC_CAP_LOG2;
                    end
                end else begin
                    blk = 64'd1 << BLOCK_LOG2;
                    if (!c.fixed_block) begin
                        need = (chip >> 1) / coeff_top;
                        if (need > blk) begin
                            blk = need;
                        end
                    end
                    len = blk * coeff;
                end
                if (len > chip) begin
                    len = chip;
                end
            end
            if (cmp) begin
                len = chip - len;
                top = !top;
            end
            start = (top && len > 64'd0) ? chip - len : 64'd0;
            res.range_start  = start[ADDR_W-1:0];
            res.range_length = len[ADDR_W-1:0];
            return res;
        endfunction

        function void note_input(t_cfg c, t_in_item it);
            pending_ranges.push_back(decode_range(c, it));
        endfunction

        task report(string what);
            $display("mismatch at %0t: %s", $time, what);
            errors++;
        endtask

        task check_result(t_out_item got);
            t_out_item want;
            if (pending_ranges.size() == 0) begin
                report($sformatf("unexpected result start %h length %h",
                                 got.range_start, got.range_length));
            end else begin
                want = pending_ranges.pop_front();
                if (got.range_start !== want.range_start) begin
                    report($sformatf("range_start got %h want %h",
                                     got.range_start, want.range_start));
                end
                if (got.range_length !== want.range_length) begin
                    report($sformatf("range_length got %h want %h",
                                     got.range_length, want.range_length));
                end
            end
        endtask

        task flush_check();
            while (pending_ranges.size() != 0) begin
                report("range never returned");
                void'(pending_ranges.pop_front());
            end
        endtask
    endclass

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_wdata;

    fwp_in_if  in_ch();
    fwp_out_if out_ch();

    flash_write_protect_range_decode DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (in_ch),
        .o_out       (out_ch),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata)
    );

    protect_range_checker ranges = new();
    t_cfg                 cfg_model;
    int                   send_gap_pct;
    int                   sink_stall_pct;
    int                   quiet_cycles;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // result side: check each transaction, then pick the next ready
    initial begin
        out_ch.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && out_ch.valid && out_ch.ready) begin
                ranges.check_result(out_ch.data);
            end
            out_ch.ready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    initial begin
        quiet_cycles = 0;
        while (quiet_cycles < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
        end
        $display("[flash_write_protect_range_decode] ERROR");
        $finish;
    end

    task automatic write_reg(t_cfg_idx idx, logic [CFG_DATA_W-1:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
    endtask

    task automatic apply_config(t_cfg c);
        write_reg(CFG_CHIP_SIZE_LOG2, CFG_DATA_W'(c.chip_size_log2));
        write_reg(CFG_BP_WIDTH, CFG_DATA_W'(c.bp_width));
        write_reg(CFG_FIXED_BLOCK, CFG_DATA_W'(c.fixed_block));
        write_reg(CFG_CMP_INVERTS_BP, CFG_DATA_W'(c.cmp_inverts_bp));
        write_reg(CFG_COEFF_SHIFT_OFFSET, CFG_DATA_W'(c.coeff_shift_offset));
        write_reg(CFG_HAS_CMP, CFG_DATA_W'(c.has_cmp));
        write_reg(CFG_HAS_SEC, CFG_DATA_W'(c.has_sec));
        write_reg(CFG_HAS_TB, CFG_DATA_W'(c.has_tb));
        i_cfg_we  <= 1'b0;
        cfg_model = c;
    endtask

    task automatic send_item(t_in_item it);
        while ($urandom_range(99) < send_gap_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.data  <= it;
        @(posedge i_clk);
        while (!in_ch.ready) begin
            @(posedge i_clk);
        end
        ranges.note_input(cfg_model, it);
    endtask

    task automatic drain_ranges();
        in_ch.valid <= 1'b0;
        while (ranges.pending_ranges.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    function automatic t_cfg random_config();
        t_cfg c;
        c.chip_size_log2     = ($urandom_range(3) == 0) ? CSL_W'($urandom_range(31))
                                                        : CSL_W'($urandom_range(31, 12));
        c.bp_width           = ($urandom_range(3) == 0) ? BPW_W'($urandom_range(7))
                                                        : BPW_W'($urandom_range(4, 2));
        c.fixed_block        = 1'($urandom_range(1));
        c.cmp_inverts_bp     = 1'($urandom_range(1));
        c.coeff_shift_offset = 1'($urandom_range(1));
        c.has_cmp            = 1'($urandom_range(1));
        c.has_sec            = 1'($urandom_range(1));
        c.has_tb             = 1'($urandom_range(1));
        return c;
    endfunction

    initial begin
        t_cfg     edge_cfgs[8];
        int       gap_prof[4];
        int       stall_prof[4];
        t_in_item it;
        int       seg;
        int       k;

        edge_cfgs[0] = '{5'd12, 3'd4, 1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b1};
        edge_cfgs[1] = '{5'd31, 3'd4, 1'b0, 1'b0, 1'b1, 1'b1, 1'b1, 1'b1};
        edge_cfgs[2] = '{5'd31, 3'd7, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1};
        edge_cfgs[3] = '{5'd3,  3'd3, 1'b0, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1};
        edge_cfgs[4] = '{5'd0,  3'd0, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1};
        edge_cfgs[5] = '{5'd20, 3'd1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1};
        edge_cfgs[6] = '{5'd16, 3'd2, 1'b1, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0};
        edge_cfgs[7] = '{5'd31, 3'd5, 1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b1};
        gap_prof     = '{0, 45, 0, 9};
        stall_prof   = '{0, 0, 45, 9};

        send_gap_pct   = 0;
        sink_stall_pct = 0;
        i_rst_n        = 1'b0;
        i_cfg_we       = 1'b0;
        i_cfg_idx      = CFG_CHIP_SIZE_LOG2;
        i_cfg_wdata    = '0;
        in_ch.valid    = 1'b0;
        in_ch.data     = '0;
        cfg_model      = '{RST_CHIP_SIZE_LOG2, RST_BP_WIDTH, 1'b0, 1'b0,
                           RST_COEFF_OFFSET, 1'b0, 1'b0, 1'b0};

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // register defaults: tb, sec and cmp bits absent
        send_item('{4'h0, 1'b1, 1'b1, 1'b1});
        send_item('{4'h7, 1'b1, 1'b1, 1'b1});
        send_item('{4'h3, 1'b0, 1'b1, 1'b1});
        send_item('{4'hF, 1'b1, 1'b1, 1'b1});
        drain_ranges();

        // every bp value with all optional bits present
        apply_config('{5'd24, 3'd4, 1'b0, 1'b0, 1'b1, 1'b1, 1'b1, 1'b1});
        for (k = 0; k < 16; k++) begin
            send_item('{k[3:0], k[0], k[1] ^ k[2], k[3]});
        end
        drain_ranges();

        for (seg = 0; seg < SEGMENTS; seg++) begin
            apply_config((seg < 8) ? edge_cfgs[seg] : random_config());
            send_gap_pct   = gap_prof[seg % 4];
            sink_stall_pct = stall_prof[seg % 4];
            for (k = 0; k < SEG_ITEMS; k++) begin
                it.bp_field      = BP_W'($urandom_range(15));
                it.top_bottom    = 1'($urandom_range(1));
                it.sector_select = 1'($urandom_range(1));
                it.complement    = 1'($urandom_range(1));
                send_item(it);
                if (k == SEG_ITEMS / 2 && $urandom_range(3) == 0) begin
                    drain_ranges();
                end
            end
            drain_ranges();
        end

        sink_stall_pct = 0;
        repeat (4) @(posedge i_clk);
        ranges.flush_check();
        if (ranges.errors == 0) begin
            $display("[flash_write_protect_range_decode] OK");
        end else begin
            $display("[flash_write_protect_range_decode] ERROR");
        end
        $finish;
    end

endmodule

@@ files.f @@
hw/rtl/fwp_pkg.sv
hw/rtl/fwp_in_if.sv
hw/rtl/fwp_out_if.sv
hw/rtl/fwp_cfg_regs.sv
hw/rtl/fwp_decode.sv
hw/rtl/flash_write_protect_range_decode.sv
test/tb_top.sv
